// ----- rtl/pidfd_pkg.sv -----
`default_nettype none

package pidfd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int STEP_W     = 16;
  localparam int ALPHA_W    = 17;
  localparam int CFG_IDX_W  = 3;

  localparam int QUO_W  = DATA_WIDTH + 1;
  localparam int DIVD_W = DATA_WIDTH + STEP_W;
  localparam int CNT_W  = $clog2(QUO_W);
  localparam int WIDE_W = DATA_WIDTH + 4;
  localparam int PROD_W = 2 * DATA_WIDTH;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << STEP_W;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUM_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUM_HIGH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_FACTOR = 3'd7;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    data_t             setpoint;
    data_t             measurement;
    logic [STEP_W-1:0] step_time;
    logic              integral_on;
    logic              anti_windup_on;
    logic              zero_integral_when_off;
    logic              clear_state;
  } in_item_t;

  typedef struct packed {
    data_t drive;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/pidfd_in_if.sv -----
`default_nettype none

interface pidfd_in_if import pidfd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pidfd_out_if.sv -----
`default_nettype none

interface pidfd_out_if import pidfd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pid_filtered_derivative_antiwindup_top.sv -----
// Each item runs through the states from S_IDLE to S_DONE. A new item is taken only in S_IDLE,
// so not before the last one is through, and later while a result waits.
// A primed step runs the 33-step restoring divider for the derivative unless the quotient would overflow.
// Clear requests and zero step times go straight to S_DONE; an unprimed step skips the divider and filter.
// rst (synchronous, active high) restores register defaults and clears the FSM, output valid and filter state.
`default_nettype none

module pid_filtered_derivative_antiwindup_top import pidfd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_WIDTH-1:0] cfg_data,
  pidfd_in_if.sink                  item,
  pidfd_out_if.source               result
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_ERR   = 20'h00002,
    S_PMUL  = 20'h00004,
    S_PRND  = 20'h00008,
    S_DSUB  = 20'h00010,
    S_DCHK  = 20'h00020,
    S_DDIV  = 20'h00040,
    S_DFIN  = 20'h00080,
    S_DMUL  = 20'h00100,
    S_DRND  = 20'h00200,
    S_FSUB  = 20'h00400,
    S_FMUL  = 20'h00800,
    S_FRND  = 20'h01000,
    S_IMUL  = 20'h02000,
    S_IRND  = 20'h04000,
    S_ISMUL = 20'h08000,
    S_ISRND = 20'h10000,
    S_SUM   = 20'h20000,
    S_CLAMP = 20'h40000,
    S_DONE  = 20'h80000
  } state_t;

  localparam logic [PROD_W-1:0] MAG_LIM  = PROD_W'(1) << (DATA_WIDTH - 1);
  localparam logic [PROD_W-1:0] RND_FRAC = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] RND_STEP = PROD_W'(1) << (STEP_W - 1);
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(QUO_W - 1);

  function automatic logic [DATA_WIDTH-1:0] mag(input data_t v);
    return v[DATA_WIDTH-1] ? DATA_WIDTH'(-v) : DATA_WIDTH'(v);
  endfunction

  function automatic data_t sat_mag(input logic neg, input logic [PROD_W-1:0] m);
    if (neg) begin
      if (m > MAG_LIM) return DATA_MIN;
      return -$signed(m[DATA_WIDTH-1:0]);
    end
    if (m >= MAG_LIM) return DATA_MAX;
    return $signed(m[DATA_WIDTH-1:0]);
  endfunction

  function automatic data_t sat_wide(input logic signed [WIDE_W-1:0] v);
    if (v > WIDE_W'(DATA_MAX)) return DATA_MAX;
    if (v < WIDE_W'(DATA_MIN)) return DATA_MIN;
    return data_t'(v);
  endfunction

  function automatic data_t clamp(input data_t v, input data_t lo, input data_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  state_t state;

  data_t              prop_gain, integral_gain, deriv_gain;
  data_t              drive_low, drive_high, accum_low, accum_high;
  logic [ALPHA_W-1:0] smooth_factor;

  data_t integral_acc, last_measurement, filtered_deriv;
  logic  primed;

  data_t             sp, ms;
  logic [STEP_W-1:0] dt;
  logic              ion, aw, zoff;

  data_t err, p_term, diff, dmeas, dterm, fdiff, itmp, inew, unc, res;

  logic [STEP_W:0]   rem;
  logic [QUO_W-1:0]  dq;
  logic [CNT_W-1:0]  cnt;

  logic [PROD_W-1:0]     prod;
  logic                  prod_neg, prod_q16;
  logic [DATA_WIDTH-1:0] mul_a, mul_b;
  logic                  mul_neg, mul_q16, mul_en;
  logic [PROD_W-1:0]     rnd_mag;
  data_t                 rnd;

  data_t                    add_a, add_b, add_c;
  logic                     add_sub;
  logic signed [WIDE_W-1:0] add_sum;
  data_t                    add_res;

  logic [ALPHA_W-1:0]  alpha;
  logic [DIVD_W-1:0]   dividend;
  logic [STEP_W:0]     rem_sh;
  logic                rem_ge;
  data_t               iapp, drv, isum;
  logic                err_pos, err_neg, hold_int;

  data_t     out_drive;
  logic      out_valid;
  out_item_t out_item;

  assign item.ready   = (state == S_IDLE);
  assign result.valid = out_valid;
  assign out_item.drive = out_drive;
  assign result.data  = out_item;

  assign alpha = (smooth_factor > ALPHA_ONE) ? ALPHA_ONE : smooth_factor;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    mul_q16 = 1'b1;
    mul_en  = 1'b1;
    unique case (state)
      S_PMUL: begin
        mul_a   = mag(prop_gain);
        mul_b   = mag(err);
        mul_neg = prop_gain[DATA_WIDTH-1] ^ err[DATA_WIDTH-1];
      end
      S_DMUL: begin
        mul_a   = mag(deriv_gain);
        mul_b   = mag(dmeas);
        mul_neg = deriv_gain[DATA_WIDTH-1] ^ dmeas[DATA_WIDTH-1];
      end
      S_FMUL: begin
        mul_a   = mag(fdiff);
        mul_b   = DATA_WIDTH'(alpha);
        mul_neg = fdiff[DATA_WIDTH-1];
        mul_q16 = 1'b0;
      end
      S_IMUL: begin
        mul_a   = mag(integral_gain);
        mul_b   = mag(err);
        mul_neg = integral_gain[DATA_WIDTH-1] ^ err[DATA_WIDTH-1];
      end
      S_ISMUL: begin
        mul_a   = mag(itmp);
        mul_b   = DATA_WIDTH'(dt);
        mul_neg = itmp[DATA_WIDTH-1];
        mul_q16 = 1'b0;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign rnd_mag = prod_q16 ? ((prod + RND_FRAC) >> FRAC_BITS)
                            : ((prod + RND_STEP) >> STEP_W);
  assign rnd     = sat_mag(prod_neg, rnd_mag);

  assign iapp = ion ? inew : '0;

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_c   = '0;
    add_sub = 1'b0;
    unique case (state)
      S_ERR: begin
        add_a   = sp;
        add_b   = ms;
        add_sub = 1'b1;
      end
      S_DSUB: begin
        add_a   = ms;
        add_b   = last_measurement;
        add_sub = 1'b1;
      end
      S_DRND: begin
        add_b   = rnd;
        add_sub = 1'b1;
      end
      S_FSUB: begin
        add_a   = dterm;
        add_b   = filtered_deriv;
        add_sub = 1'b1;
      end
      S_FRND: begin
        add_a = filtered_deriv;
        add_c = rnd;
      end
      S_ISRND: begin
        add_a = integral_acc;
        add_c = rnd;
      end
      S_SUM: begin
        add_a = p_term;
        add_b = iapp;
        add_c = filtered_deriv;
      end
      default: ;
    endcase
  end

  assign add_sum = WIDE_W'(add_a) + (add_sub ? -WIDE_W'(add_b) : WIDE_W'(add_b))
                 + WIDE_W'(add_c);
  assign add_res = sat_wide(add_sum);

  assign dividend = {mag(diff), {STEP_W{1'b0}}} + DIVD_W'(dt >> 1);
  assign rem_sh   = {rem[STEP_W-1:0], dq[QUO_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, dt};

  assign isum     = add_res;
  assign drv      = clamp(unc, drive_low, drive_high);
  assign err_pos  = !err[DATA_WIDTH-1] && (err != '0);
  assign err_neg  = err[DATA_WIDTH-1];
  assign hold_int = aw && (drv != unc)
                  && (((drv == drive_high) && err_pos) || ((drv == drive_low) && err_neg));

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod     <= PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_neg <= mul_neg;
      prod_q16 <= mul_q16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= '0;
      integral_gain <= '0;
      deriv_gain    <= '0;
      drive_low     <= DATA_MIN;
      drive_high    <= DATA_MAX;
      accum_low     <= DATA_MIN;
      accum_high    <= DATA_MAX;
      smooth_factor <= ALPHA_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:     prop_gain     <= $signed(cfg_data);
        REG_INTEGRAL_GAIN: integral_gain <= $signed(cfg_data);
        REG_DERIV_GAIN:    deriv_gain    <= $signed(cfg_data);
        REG_DRIVE_LOW:     drive_low     <= $signed(cfg_data);
        REG_DRIVE_HIGH:    drive_high    <= $signed(cfg_data);
        REG_ACCUM_LOW:     accum_low     <= $signed(cfg_data);
        REG_ACCUM_HIGH:    accum_high    <= $signed(cfg_data);
        REG_SMOOTH_FACTOR: smooth_factor <= cfg_data[ALPHA_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      integral_acc     <= '0;
      last_measurement <= '0;
      filtered_deriv   <= '0;
      primed           <= 1'b0;
    end else begin
      if (out_valid && result.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            sp   <= item.data.setpoint;
            ms   <= item.data.measurement;
            dt   <= item.data.step_time;
            ion  <= item.data.integral_on;
            aw   <= item.data.anti_windup_on;
            zoff <= item.data.zero_integral_when_off;
            if (item.data.clear_state) begin
              integral_acc     <= '0;
              last_measurement <= '0;
              filtered_deriv   <= '0;
              primed           <= 1'b0;
              res              <= '0;
              state            <= S_DONE;
            end else if (item.data.step_time == '0) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              state <= S_ERR;
            end
          end
        end
        S_ERR: begin
          err   <= add_res;
          state <= S_PMUL;
        end
        S_PMUL: state <= S_PRND;
        S_PRND: begin
          p_term <= rnd;
          state  <= S_DSUB;
        end
        S_DSUB: begin
          if (primed) begin
            diff  <= add_res;
            state <= S_DCHK;
          end else begin
            dmeas <= '0;
            state <= S_DMUL;
          end
        end
        S_DCHK: begin
          if ({1'b0, dividend[DIVD_W-1:QUO_W]} >= dt) begin
            dmeas <= diff[DATA_WIDTH-1] ? DATA_MIN : DATA_MAX;
            state <= S_DMUL;
          end else begin
            rem   <= (STEP_W+1)'(dividend[DIVD_W-1:QUO_W]);
            dq    <= dividend[QUO_W-1:0];
            cnt   <= '0;
            state <= S_DDIV;
          end
        end
        S_DDIV: begin
          rem <= rem_ge ? (rem_sh - {1'b0, dt}) : rem_sh;
          dq  <= {dq[QUO_W-2:0], rem_ge};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          dmeas <= sat_mag(diff[DATA_WIDTH-1], PROD_W'(dq));
          state <= S_DMUL;
        end
        S_DMUL: state <= S_DRND;
        S_DRND: begin
          dterm <= add_res;
          state <= S_FSUB;
        end
        S_FSUB: begin
          primed <= 1'b1;
          if (primed) begin
            fdiff <= add_res;
            state <= S_FMUL;
          end else begin
            filtered_deriv <= dterm;
            state          <= S_IMUL;
          end
        end
        S_FMUL: state <= S_FRND;
        S_FRND: begin
          filtered_deriv <= add_res;
          state          <= S_IMUL;
        end
        S_IMUL: begin
          if (ion) begin
            state <= S_IRND;
          end else begin
            inew  <= zoff ? '0 : integral_acc;
            state <= S_SUM;
          end
        end
        S_IRND: begin
          itmp  <= rnd;
          state <= S_ISMUL;
        end
        S_ISMUL: state <= S_ISRND;
        S_ISRND: begin
          inew  <= aw ? clamp(isum, accum_low, accum_high) : isum;
          state <= S_SUM;
        end
        S_SUM: begin
          unc   <= add_res;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          res              <= drv;
          last_measurement <= ms;
          if (!hold_int) begin
            integral_acc <= inew;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_drive <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
